// ===== rtl/core/rxs_pkg.sv =====
// ----------------------------------------------------------------------------
// rxs_pkg: shared types and helpers for the record exchange sorter
// Record layout, controller states, the command group from the controller to
// the datapath, and the name cleanup function.
// ----------------------------------------------------------------------------
package rxs_pkg;

  localparam int ID_W            = 27;
  localparam int GRADE_W         = 4;
  localparam int NAME_W          = 64;
  localparam int SUM_W           = GRADE_W + 1;
  localparam int DEF_MAX_RECORDS = 64;
  localparam int DEF_NAME_CHARS  = 16;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [GRADE_W-1:0] grade_a;
    logic [GRADE_W-1:0] grade_b;
    logic [NAME_W-1:0]  head;
    logic [NAME_W-1:0]  tail;
  } rec_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_START,
    ST_SORT_HOLD,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } rxs_state_t;

  typedef enum logic {
    WSEL_INPUT,
    WSEL_HELD
  } wsel_t;

  typedef struct packed {
    logic  wr_en;
    wsel_t wsel;
    logic  held_ld;
    logic  out_ld;
    logic  out_end;
    logic  out_drop;
  } cmd_t;

  // Zeroes every character after the first zero character and every
  // character beyond the configured name length.
  function automatic logic [2*NAME_W-1:0] name_clean(
    input logic [NAME_W-1:0] head,
    input logic [NAME_W-1:0] tail,
    input int                chars
  );
    logic [2*NAME_W-1:0] word;
    logic [2*NAME_W-1:0] res;
    logic                alive;
    word  = {head, tail};
    res   = '0;
    alive = 1'b1;
    for (int k = 0; k < 2*NAME_W/8; k++) begin
      alive = alive && (word[2*NAME_W-1-8*k -: 8] != 8'd0) && (k < chars);
      if (alive) begin
        res[2*NAME_W-1-8*k -: 8] = word[2*NAME_W-1-8*k -: 8];
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/rxs_datapath.sv =====
// ----------------------------------------------------------------------------
// rxs_datapath: record store, held entry, comparator and output register
// Holds the record memory with one write and one registered read port, the
// entry currently held for the outer sort index, and the result register.
// ----------------------------------------------------------------------------
module rxs_datapath
  import rxs_pkg::*;
#(
  parameter int MAX_RECORDS = DEF_MAX_RECORDS,
  parameter int NAME_CHARS  = DEF_NAME_CHARS,
  localparam int AW         = $clog2(MAX_RECORDS)
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [AW-1:0]      wr_addr,
  input  logic [AW-1:0]      rd_addr,
  output logic               swap,
  input  logic [ID_W-1:0]    student_id,
  input  logic [GRADE_W-1:0] grade_first,
  input  logic [GRADE_W-1:0] grade_second,
  input  logic [NAME_W-1:0]  name_head,
  input  logic [NAME_W-1:0]  name_tail,
  input  logic               cfg_write,
  input  logic               cfg_data,
  output logic [ID_W-1:0]    out_id,
  output logic [GRADE_W-1:0] out_grade_first,
  output logic [GRADE_W-1:0] out_grade_second,
  output logic [NAME_W-1:0]  out_name_head,
  output logic [NAME_W-1:0]  out_name_tail,
  output logic               end_of_run,
  output logic               dropped_flag
);

  rec_t mem [MAX_RECORDS];
  rec_t rd_data;
  rec_t held;
  rec_t out_rec;
  rec_t in_rec;
  rec_t wr_data;
  logic sort_mode;

  logic [2*NAME_W-1:0] in_name;
  logic [2*NAME_W-1:0] name_held;
  logic [2*NAME_W-1:0] name_rd;
  logic [SUM_W-1:0]    sum_held;
  logic [SUM_W-1:0]    sum_rd;

  always_comb begin
    in_name         = name_clean(name_head, name_tail, NAME_CHARS);
    in_rec.id       = student_id;
    in_rec.grade_a  = grade_first;
    in_rec.grade_b  = grade_second;
    in_rec.head     = in_name[2*NAME_W-1:NAME_W];
    in_rec.tail     = in_name[NAME_W-1:0];
    wr_data         = (cmd.wsel == WSEL_HELD) ? held : in_rec;
  end

  // Held entry sits at the outer index; it moves down when the scanned
  // entry orders before it.
  always_comb begin
    name_held = {held.head, held.tail};
    name_rd   = {rd_data.head, rd_data.tail};
    sum_held  = {1'b0, held.grade_a} + {1'b0, held.grade_b};
    sum_rd    = {1'b0, rd_data.grade_a} + {1'b0, rd_data.grade_b};
    swap      = (name_held > name_rd) ||
                ((name_held == name_rd) && sort_mode && (sum_held > sum_rd));
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.held_ld) begin
      held <= rd_data;
    end
    if (cmd.out_ld) begin
      out_rec      <= rd_data;
      end_of_run   <= cmd.out_end;
      dropped_flag <= cmd.out_drop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_mode <= 1'b1;
    end else if (cfg_write) begin
      sort_mode <= cfg_data;
    end
  end

  assign out_id           = out_rec.id;
  assign out_grade_first  = out_rec.grade_a;
  assign out_grade_second = out_rec.grade_b;
  assign out_name_head    = out_rec.head;
  assign out_name_tail    = out_rec.tail;

endmodule

// ===== rtl/core/rxs_ctrl.sv =====
// ----------------------------------------------------------------------------
// rxs_ctrl: sequencer for load, exchange sort and emit
// Owns the record count, overflow flag and the sort and emit indexes, and
// issues memory and register commands to the datapath.
// ----------------------------------------------------------------------------
module rxs_ctrl
  import rxs_pkg::*;
#(
  parameter int MAX_RECORDS = DEF_MAX_RECORDS,
  localparam int AW         = $clog2(MAX_RECORDS),
  localparam int CW         = $clog2(MAX_RECORDS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          is_last,
  output logic          out_valid,
  input  logic          out_stall,
  input  logic          swap,
  output cmd_t          cmd,
  output logic [AW-1:0] wr_addr,
  output logic [AW-1:0] rd_addr
);

  rxs_state_t    state, state_next;
  logic [CW-1:0] count, count_next;
  logic          overflow, overflow_next;
  logic [AW-1:0] idx_i, idx_i_next;
  logic [AW-1:0] idx_j, idx_j_next;
  logic [AW-1:0] idx_k, idx_k_next;
  logic [CW-1:0] count_m1;
  logic [AW-1:0] last_idx;

  assign count_m1  = count - 1'b1;
  assign last_idx  = count_m1[AW-1:0];
  assign in_stall  = (state != ST_LOAD);
  assign out_valid = (state == ST_EMIT_WAIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      overflow <= overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    idx_i <= idx_i_next;
    idx_j <= idx_j_next;
    idx_k <= idx_k_next;
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    overflow_next = overflow;
    idx_i_next    = idx_i;
    idx_j_next    = idx_j;
    idx_k_next    = idx_k;
    cmd           = '0;
    wr_addr       = '0;
    rd_addr       = '0;
    unique case (state)
      ST_LOAD: begin
        if (in_valid) begin
          if (count < CW'(MAX_RECORDS)) begin
            cmd.wr_en  = 1'b1;
            cmd.wsel   = WSEL_INPUT;
            wr_addr    = count[AW-1:0];
            count_next = count + 1'b1;
          end else begin
            overflow_next = 1'b1;
          end
          if (is_last) begin
            state_next = ST_SORT_START;
          end
        end
      end
      ST_SORT_START: begin
        idx_i_next = '0;
        idx_k_next = '0;
        if (count < CW'(2)) begin
          state_next = ST_EMIT_RD;
        end else begin
          rd_addr    = '0;
          state_next = ST_SORT_HOLD;
        end
      end
      ST_SORT_HOLD: begin
        cmd.held_ld = 1'b1;
        rd_addr     = idx_i + 1'b1;
        idx_j_next  = idx_i + 1'b1;
        state_next  = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        if (swap) begin
          cmd.wr_en   = 1'b1;
          cmd.wsel    = WSEL_HELD;
          cmd.held_ld = 1'b1;
          wr_addr     = idx_j;
        end
        if (idx_j == last_idx) begin
          state_next = ST_SORT_PUT;
        end else begin
          idx_j_next = idx_j + 1'b1;
          rd_addr    = idx_j + 1'b1;
        end
      end
      ST_SORT_PUT: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = WSEL_HELD;
        wr_addr   = idx_i;
        if (idx_i + 1'b1 == last_idx) begin
          idx_k_next = '0;
          state_next = ST_EMIT_RD;
        end else begin
          idx_i_next = idx_i + 1'b1;
          rd_addr    = idx_i + 1'b1;
          state_next = ST_SORT_HOLD;
        end
      end
      ST_EMIT_RD: begin
        rd_addr    = idx_k;
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd.out_ld   = 1'b1;
        cmd.out_end  = (idx_k == last_idx);
        cmd.out_drop = overflow;
        state_next   = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (!out_stall) begin
          if (idx_k == last_idx) begin
            count_next    = '0;
            overflow_next = 1'b0;
            state_next    = ST_LOAD;
          end else begin
            idx_k_next = idx_k + 1'b1;
            rd_addr    = idx_k + 1'b1;
            state_next = ST_EMIT_LD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== rtl/core/record_exchange_sort_by_name.sv =====
// ----------------------------------------------------------------------------
// record_exchange_sort_by_name: collects records, sorts them by name, emits
// Loading stores each accepted record up to MAX_RECORDS, until the one marked
// last. The exchange sort then makes one compare per cycle in its inner
// scan, through the single read and write port of the record memory. Each
// emitted record waits in the output register while the output is stalled.
// Synchronous active-high reset clears the controller, record count, drop
// flag and sets sort_mode to 1; the record memory is not cleared.
// ----------------------------------------------------------------------------
module record_exchange_sort_by_name
  import rxs_pkg::*;
#(
  parameter int MAX_RECORDS = DEF_MAX_RECORDS,
  parameter int NAME_CHARS  = DEF_NAME_CHARS
) (
  input  logic               clk,
  input  logic               rst,
  // Record input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ID_W-1:0]    student_id,
  input  logic [GRADE_W-1:0] grade_first,
  input  logic [GRADE_W-1:0] grade_second,
  input  logic [NAME_W-1:0]  name_head,
  input  logic [NAME_W-1:0]  name_tail,
  input  logic               is_last,
  // Sorted record output channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ID_W-1:0]    out_id,
  output logic [GRADE_W-1:0] out_grade_first,
  output logic [GRADE_W-1:0] out_grade_second,
  output logic [NAME_W-1:0]  out_name_head,
  output logic [NAME_W-1:0]  out_name_tail,
  output logic               end_of_run,
  output logic               dropped_flag,
  // Configuration write channel for sort_mode.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  localparam int AW = $clog2(MAX_RECORDS);

  cmd_t          cmd;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          swap;

  // The mode register can take a write on any cycle.
  assign cfg_ready = 1'b1;

  // The controller walks the outer index i and inner index j of the exchange
  // sort. The entry at i stays in a held register for the whole inner scan;
  // each scanned entry that orders before it trades places with it, so only
  // position j is written during the scan and position i once at its end.
  rxs_ctrl #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .is_last   (is_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .swap      (swap),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr)
  );

  // The datapath cleans incoming names so that the packed compare matches a
  // string compare, stores records, compares the held entry with the scanned
  // one, and holds each emitted beat in an output register.
  rxs_datapath #(
    .MAX_RECORDS (MAX_RECORDS),
    .NAME_CHARS  (NAME_CHARS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .wr_addr          (wr_addr),
    .rd_addr          (rd_addr),
    .swap             (swap),
    .student_id       (student_id),
    .grade_first      (grade_first),
    .grade_second     (grade_second),
    .name_head        (name_head),
    .name_tail        (name_tail),
    .cfg_write        (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .out_id           (out_id),
    .out_grade_first  (out_grade_first),
    .out_grade_second (out_grade_second),
    .out_name_head    (out_name_head),
    .out_name_tail    (out_name_tail),
    .end_of_run       (end_of_run),
    .dropped_flag     (dropped_flag)
  );

  // Input and output are never open at the same time.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input open while a result is pending");

  // A record from the input port is written only on an accepted beat.
  a_load_on_beat: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_en && cmd.wsel == WSEL_INPUT) |-> (in_valid && !in_stall))
    else $error("record stored without an input beat");

  // After the final beat of a run the block is ready for a new set.
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && end_of_run) |=> (!in_stall && !out_valid))
    else $error("input not reopened after the end of a run");

  // The output register is never loaded while a result waits.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> !out_valid)
    else $error("output register reloaded over a pending result");

endmodule

// ===== test/tb_record_exchange_sort_by_name.sv =====
// ----------------------------------------------------------------------------
// tb_record_exchange_sort_by_name: self-checking bench for the name sorter
// Records are streamed into the sorter in sets. Each set closes with a record
// marked last. A behavioral roster in the bench keeps its own copy of the
// stored records and sorts them the same way. Every sorted beat that comes
// out is then compared field by field with the roster's prediction.
// Directed sets come first. Random sets follow, in phases that switch the
// sort mode and the idle and stall pressure on both channels.
// ----------------------------------------------------------------------------
module tb_record_exchange_sort_by_name;
  import rxs_pkg::*;

  localparam int ROSTER_DEPTH = DEF_MAX_RECORDS;
  localparam int NAME_LEN     = DEF_NAME_CHARS;
  // Cycles with no beat on any channel before the run is declared hung. The
  // longest honest quiet spell is a full 64-record sort or the long receiver
  // hold-off.
  localparam int QUIET_LIMIT  = 12000;
  localparam int HOLD_CYCLES  = 500;
  // Cycles left for the controller to return to loading after its last beat.
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 35;

  // One expected beat on the sorted output.
  typedef struct packed {
    rec_t rec;
    logic run_end;
    logic dropped;
  } sorted_beat_t;

  // One row of the directed table. Rows marked typed carry their expected
  // name words. Those rows are single-record sets, so id and grades come back
  // unchanged, end_of_run is high and nothing is dropped.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [GRADE_W-1:0] g1;
    logic [GRADE_W-1:0] g2;
    logic [NAME_W-1:0]  head;
    logic [NAME_W-1:0]  tail;
    logic               last;
    logic               typed;
    logic [NAME_W-1:0]  want_head;
    logic [NAME_W-1:0]  want_tail;
  } directed_row_t;

  localparam logic [NAME_W-1:0] NM_A    = 64'h4100_0000_0000_0000;
  localparam logic [NAME_W-1:0] NM_B    = 64'h4200_0000_0000_0000;
  localparam logic [NAME_W-1:0] NM_FULL = 64'h4142_4344_4546_4748;
  localparam logic [NAME_W-1:0] ONES    = '1;

  localparam int DIRECTED_ROWS = 15;
  localparam directed_row_t DIRECTED_PLAN [DIRECTED_ROWS] = '{
    // All fields at zero: an empty name with zero id and grades.
    '{27'd0, 4'd0, 4'd0, 64'd0, 64'd0, 1'b1, 1'b1, 64'd0, 64'd0},
    // All bits set: grades above ten, sixteen characters of 0xFF kept.
    '{27'h7FF_FFFF, 4'd15, 4'd15, ONES, ONES, 1'b1, 1'b1, ONES, ONES},
    // Terminator after the first character wipes the rest of both words.
    '{27'd99999999, 4'd10, 4'd10, 64'h4100_FFFF_FFFF_FFFF, ONES, 1'b1, 1'b1,
      NM_A, 64'd0},
    // Empty name with garbage behind the leading zero character.
    '{27'd12345, 4'd3, 4'd7, 64'h0000_4142_4344_4546, NM_FULL, 1'b1, 1'b1,
      64'd0, 64'd0},
    // Terminator in the tail word only.
    '{27'd777, 4'd1, 4'd2, NM_FULL, 64'h5A00_7F7F_7F7F_7F7F, 1'b1, 1'b1,
      NM_FULL, 64'h5A00_0000_0000_0000},
    // Terminator in the last head character hides the whole tail.
    '{27'd778, 4'd9, 4'd0, 64'h4142_4344_4546_4700, NM_FULL, 1'b1, 1'b1,
      64'h4142_4344_4546_4700, 64'd0},
    // Five records with tied names: order by grade sum in mode 1, and the
    // equal-sum B records swap. One "A" carries garbage after its terminator.
    '{27'd101, 4'd4, 4'd4, NM_B, 64'd0, 1'b0, 1'b0, 64'd0, 64'd0},
    '{27'd102, 4'd10, 4'd10, NM_A, 64'd0, 1'b0, 1'b0, 64'd0, 64'd0},
    '{27'd103, 4'd1, 4'd2, 64'h4100_1234_5678_9ABC, ONES, 1'b0, 1'b0, 64'd0, 64'd0},
    '{27'd104, 4'd5, 4'd3, NM_B, 64'd0, 1'b0, 1'b0, 64'd0, 64'd0},
    '{27'd105, 4'd15, 4'd0, NM_A, 64'd0, 1'b1, 1'b0, 64'd0, 64'd0},
    // Three records that differ only in the tail, plus a shorter prefix.
    '{27'd201, 4'd0, 4'd0, NM_FULL, 64'h5A00_0000_0000_0000, 1'b0, 1'b0, 64'd0, 64'd0},
    '{27'd202, 4'd0, 4'd0, NM_FULL, 64'h5900_0000_0000_0000, 1'b0, 1'b0, 64'd0, 64'd0},
    '{27'd203, 4'd0, 4'd0, NM_FULL, 64'h5A41_0000_0000_0000, 1'b0, 1'b0, 64'd0, 64'd0},
    '{27'd204, 4'd0, 4'd0, 64'h4142_4344_4546_4700, 64'd0, 1'b1, 1'b0, 64'd0, 64'd0}
  };

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [ID_W-1:0]    student_id;
  logic [GRADE_W-1:0] grade_first;
  logic [GRADE_W-1:0] grade_second;
  logic [NAME_W-1:0]  name_head;
  logic [NAME_W-1:0]  name_tail;
  logic               is_last;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ID_W-1:0]    out_id;
  logic [GRADE_W-1:0] out_grade_first;
  logic [GRADE_W-1:0] out_grade_second;
  logic [NAME_W-1:0]  out_name_head;
  logic [NAME_W-1:0]  out_name_tail;
  logic               end_of_run;
  logic               dropped_flag;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_data;

  record_exchange_sort_by_name #(
    .MAX_RECORDS(ROSTER_DEPTH),
    .NAME_CHARS (NAME_LEN)
  ) uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .student_id      (student_id),
    .grade_first     (grade_first),
    .grade_second    (grade_second),
    .name_head       (name_head),
    .name_tail       (name_tail),
    .is_last         (is_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_id          (out_id),
    .out_grade_first (out_grade_first),
    .out_grade_second(out_grade_second),
    .out_name_head   (out_name_head),
    .out_name_tail   (out_name_tail),
    .end_of_run      (end_of_run),
    .dropped_flag    (dropped_flag),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Behavioral roster: the records of the open set, the drop flag and the
  // sort mode, mirrored from what the sorter has accepted.
  rec_t         roster [ROSTER_DEPTH];
  int unsigned  roster_count = 0;
  logic         roster_overflow = 1'b0;
  logic         by_average = 1'b1;
  sorted_beat_t expected_beats [$];

  int mismatch_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int phase_items = 0;
  logic hold_req = 1'b0;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;
  wire cfg_fire = cfg_valid && cfg_ready;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [NAME_W-1:0] got,
                             input logic [NAME_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h expected %h", what, got, want));
    end
  endtask

  // A name ends at its first zero character. Everything after it, and
  // everything past the configured length, reads as zero so that an unsigned
  // compare of the two words orders names like a string compare.
  function automatic logic [2*NAME_W-1:0] terminate_name(
    input logic [2*NAME_W-1:0] raw
  );
    logic [2*NAME_W-1:0] nm;
    logic                ended;
    nm    = raw;
    ended = 1'b0;
    for (int k = 0; k < 2*NAME_W/8; k++) begin
      if (k >= NAME_LEN || raw[2*NAME_W-1-8*k -: 8] == 8'h00) begin
        ended = 1'b1;
      end
      if (ended) begin
        nm[2*NAME_W-1-8*k -: 8] = 8'h00;
      end
    end
    return nm;
  endfunction

  function automatic logic [SUM_W-1:0] grade_total(input rec_t r);
    return SUM_W'(r.grade_a) + SUM_W'(r.grade_b);
  endfunction

  // Entry a moves behind entry b when its name is larger, or, with the
  // average ordering on, when the names match and its grade sum is larger.
  function automatic logic out_of_order(input rec_t a, input rec_t b);
    if ({a.head, a.tail} != {b.head, b.tail}) begin
      return {a.head, a.tail} > {b.head, b.tail};
    end
    return by_average && (grade_total(a) > grade_total(b));
  endfunction

  // Takes one accepted record into the roster. On a last record the roster
  // is sorted in place and every entry is queued as an expected beat.
  task automatic absorb_record(input rec_t r, input logic last);
    rec_t         held;
    sorted_beat_t beat;
    if (roster_count < ROSTER_DEPTH) begin
      held = r;
      {held.head, held.tail} = terminate_name({r.head, r.tail});
      roster[roster_count] = held;
      roster_count++;
    end else begin
      roster_overflow = 1'b1;
    end
    if (!last) begin
      return;
    end
    for (int i = 0; i + 1 < roster_count; i++) begin
      for (int j = i + 1; j < roster_count; j++) begin
        if (out_of_order(roster[i], roster[j])) begin
          held      = roster[i];
          roster[i] = roster[j];
          roster[j] = held;
        end
      end
    end
    for (int k = 0; k < roster_count; k++) begin
      beat.rec     = roster[k];
      beat.run_end = (k + 1 == roster_count);
      beat.dropped = roster_overflow;
      expected_beats.push_back(beat);
    end
    roster_count    = 0;
    roster_overflow = 1'b0;
  endtask

  // Presents one record on the input channel and holds it until it is taken.
  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so a following record goes out back to back.
  task automatic push_record(input rec_t r, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    student_id   = r.id;
    grade_first  = r.grade_a;
    grade_second = r.grade_b;
    name_head    = r.head;
    name_tail    = r.tail;
    is_last      = last;
    in_valid     = 1'b1;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    absorb_record(r, last);
    phase_items++;
    @(negedge clk);
  endtask

  // Names come in three flavors: very short names over two letters, which
  // tie often; printable names of any length; and raw bit patterns. The bytes
  // behind a terminator are left as garbage on purpose.
  function automatic logic [2*NAME_W-1:0] random_name();
    logic [2*NAME_W-1:0] nm;
    int                  flavor;
    int                  len;
    flavor = $urandom_range(0, 9);
    nm     = {$urandom, $urandom, $urandom, $urandom};
    if (flavor < 6) begin
      len = (flavor < 4) ? $urandom_range(0, 2) : $urandom_range(0, 16);
      for (int k = 0; k < 2*NAME_W/8; k++) begin
        if (k < len) begin
          nm[2*NAME_W-1-8*k -: 8] = (flavor < 4) ? 8'(8'h41 + $urandom_range(0, 1))
                                                 : 8'(8'h20 + $urandom_range(0, 94));
        end else if (k == len) begin
          nm[2*NAME_W-1-8*k -: 8] = 8'h00;
        end
      end
    end
    return nm;
  endfunction

  task automatic send_set(input int size);
    rec_t r;
    for (int k = 0; k < size; k++) begin
      r.id      = ID_W'($urandom);
      r.grade_a = GRADE_W'($urandom_range(0, 15));
      r.grade_b = GRADE_W'($urandom_range(0, 15));
      {r.head, r.tail} = random_name();
      push_record(r, k == size - 1);
    end
  endtask

  // Waits at falling edges until every predicted beat has come out, then
  // gives the controller time to get back to loading.
  task automatic settle();
    while (expected_beats.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes sort_mode. Only called while the sorter is idle.
  task automatic write_sort_mode(input logic mode);
    cfg_data  = mode;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    by_average = mode;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver side. A hold-off request freezes the output for a long stretch,
  // counted here, while the sender keeps offering records so that the sorter
  // has to push back on its input.
  always @(negedge clk) begin : receiver
    int hold_left;
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Every accepted sorted beat must match the oldest prediction.
  always @(posedge clk) begin : scoreboard
    sorted_beat_t want;
    if (out_fire) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat id %h", out_id));
      end else begin
        want = expected_beats.pop_front();
        check_field("out_id", NAME_W'(out_id), NAME_W'(want.rec.id));
        check_field("out_grade_first", NAME_W'(out_grade_first),
                    NAME_W'(want.rec.grade_a));
        check_field("out_grade_second", NAME_W'(out_grade_second),
                    NAME_W'(want.rec.grade_b));
        check_field("out_name_head", out_name_head, want.rec.head);
        check_field("out_name_tail", out_name_tail, want.rec.tail);
        check_field("end_of_run", NAME_W'(end_of_run), NAME_W'(want.run_end));
        check_field("dropped_flag", NAME_W'(dropped_flag), NAME_W'(want.dropped));
      end
    end
  end

  // Ends a hung run: too many cycles in a row without a beat on any channel.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (in_fire || out_fire || cfg_fire) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    rec_t         r;
    sorted_beat_t typed_beat;
    rst          = 1'b1;
    in_valid     = 1'b0;
    student_id   = '0;
    grade_first  = '0;
    grade_second = '0;
    name_head    = '0;
    name_tail    = '0;
    is_last      = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table, run in the reset mode (name then average). Typed rows
    // replace the roster's prediction with the value written in the table.
    for (int n = 0; n < DIRECTED_ROWS; n++) begin
      r.id      = DIRECTED_PLAN[n].id;
      r.grade_a = DIRECTED_PLAN[n].g1;
      r.grade_b = DIRECTED_PLAN[n].g2;
      r.head    = DIRECTED_PLAN[n].head;
      r.tail    = DIRECTED_PLAN[n].tail;
      push_record(r, DIRECTED_PLAN[n].last);
      if (DIRECTED_PLAN[n].typed) begin
        typed_beat.rec      = r;
        typed_beat.rec.head = DIRECTED_PLAN[n].want_head;
        typed_beat.rec.tail = DIRECTED_PLAN[n].want_tail;
        typed_beat.run_end  = 1'b1;
        typed_beat.dropped  = 1'b0;
        expected_beats[expected_beats.size() - 1] = typed_beat;
      end
    end
    in_valid = 1'b0;

    // Random phases. Even phases sort by name only, odd ones by name then
    // average. Pressure: none, idle sender, stalling receiver, then both.
    // Phase one also sends a set that fills the store exactly, and phase
    // three a set that overflows it, losing the record marked last as well.
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      write_sort_mode(phase % 2 == 1);
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 80 : 31) : 0;
      stall_pct     = (phase == 2 || phase == 3) ? ((phase == 2) ? 80 : 31) : 0;
      phase_items   = 0;
      if (phase == 0) begin
        hold_req = 1'b1;
      end
      if (phase == 1) begin
        send_set(ROSTER_DEPTH);
      end
      if (phase == 3) begin
        send_set(ROSTER_DEPTH + 2);
      end
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        send_set($urandom_range(1, 8));
      end
      in_valid = 1'b0;
    end

    settle();
    if (expected_beats.size() != 0) begin
      report_mismatch($sformatf("%0d sorted beats never arrived", expected_beats.size()));
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
